[src/nls_pkg.sv]
// Shared types and constants for the numeric literal scanner.
// No dependencies; used by every module of the block.
package nls_pkg;

   // Request and response payloads
   typedef struct packed {
      logic [20:0] character;
      logic        end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] literal_length;
      logic       took_current;
      logic       dot_returned;
   } rsp_payload_type;

   // Character classes produced by the front end, carried through the queue
   typedef struct packed {
      logic zero;      // '0'
      logic bin;       // '0'..'1'
      logic oct;       // '0'..'7'
      logic dec;       // '0'..'9'
      logic hex;       // 0-9, a-f, A-F
      logic alpha;     // a-z, A-Z
      logic pfx_hex;   // x X
      logic pfx_bin;   // b B
      logic pfx_oct;   // o O
      logic dot;       // '.'
      logic expo;      // e E
      logic sign;      // + -
      logic suffix;    // f d L
   } class_type;

   // Status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

   // Queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // Character codes
   localparam logic [20:0] CH_0     = 21'h30;
   localparam logic [20:0] CH_1     = 21'h31;
   localparam logic [20:0] CH_7     = 21'h37;
   localparam logic [20:0] CH_9     = 21'h39;
   localparam logic [20:0] CH_LC_A  = 21'h61;
   localparam logic [20:0] CH_LC_F  = 21'h66;
   localparam logic [20:0] CH_LC_Z  = 21'h7A;
   localparam logic [20:0] CH_UC_A  = 21'h41;
   localparam logic [20:0] CH_UC_F  = 21'h46;
   localparam logic [20:0] CH_UC_Z  = 21'h5A;
   localparam logic [20:0] CH_LC_X  = 21'h78;
   localparam logic [20:0] CH_UC_X  = 21'h58;
   localparam logic [20:0] CH_LC_B  = 21'h62;
   localparam logic [20:0] CH_UC_B  = 21'h42;
   localparam logic [20:0] CH_LC_O  = 21'h6F;
   localparam logic [20:0] CH_UC_O  = 21'h4F;
   localparam logic [20:0] CH_DOT   = 21'h2E;
   localparam logic [20:0] CH_LC_E  = 21'h65;
   localparam logic [20:0] CH_UC_E  = 21'h45;
   localparam logic [20:0] CH_PLUS  = 21'h2B;
   localparam logic [20:0] CH_MINUS = 21'h2D;
   localparam logic [20:0] CH_LC_D  = 21'h64;
   localparam logic [20:0] CH_UC_L  = 21'h4C;

endpackage

[src/numeric_literal_scanner.sv]
// Numeric literal scanner, top level: front classifier, queue, back state machine.
// Depends on nls_pkg, nls_front, nls_queue and nls_back.
// Throughput: one character per cycle, set by the back end's one-step state machine,
// unless a stalled response holds it. A closing request is registered into the queue,
// then passes through the state machine into the response register.
// Reset: synchronous; empties the queue, returns the scanner to idle, drops any response.
module numeric_literal_scanner #(
   parameter int MAX_LENGTH = 255
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  nls_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output nls_pkg::rsp_payload_type rsp_data
);

   nls_pkg::class_type req_class;
   nls_pkg::class_type q_head;
   logic               q_full;
   logic               q_valid;
   logic               q_pop;
   logic               q_push;

   // Queue full stalls the request side
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   nls_front u_front (
      .req_data (req_data),
      .cls      (req_class)
   );

   nls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (req_class),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head      (q_head)
   );

   nls_back #(
      .MAX_LENGTH (MAX_LENGTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

[src/nls_front.sv]
// Front end of the numeric literal scanner: classifies each request character.
// Depends on nls_pkg.
module nls_front (
   input  nls_pkg::req_payload_type req_data,
   output nls_pkg::class_type       cls
);

   logic [20:0] c;
   logic        live;

   assign c    = req_data.character;
   assign live = !req_data.end_of_text;

   // End of text matches no class at all
   always_comb begin
      cls.dec     = live && c >= nls_pkg::CH_0 && c <= nls_pkg::CH_9;
      cls.zero    = live && c == nls_pkg::CH_0;
      cls.bin     = live && (c == nls_pkg::CH_0 || c == nls_pkg::CH_1);
      cls.oct     = live && c >= nls_pkg::CH_0 && c <= nls_pkg::CH_7;
      cls.hex     = cls.dec
                    || (live && c >= nls_pkg::CH_LC_A && c <= nls_pkg::CH_LC_F)
                    || (live && c >= nls_pkg::CH_UC_A && c <= nls_pkg::CH_UC_F);
      cls.alpha   = (live && c >= nls_pkg::CH_LC_A && c <= nls_pkg::CH_LC_Z)
                    || (live && c >= nls_pkg::CH_UC_A && c <= nls_pkg::CH_UC_Z);
      cls.pfx_hex = live && (c == nls_pkg::CH_LC_X || c == nls_pkg::CH_UC_X);
      cls.pfx_bin = live && (c == nls_pkg::CH_LC_B || c == nls_pkg::CH_UC_B);
      cls.pfx_oct = live && (c == nls_pkg::CH_LC_O || c == nls_pkg::CH_UC_O);
      cls.dot     = live && c == nls_pkg::CH_DOT;
      cls.expo    = live && (c == nls_pkg::CH_LC_E || c == nls_pkg::CH_UC_E);
      cls.sign    = live && (c == nls_pkg::CH_PLUS || c == nls_pkg::CH_MINUS);
      cls.suffix  = live && (c == nls_pkg::CH_LC_F || c == nls_pkg::CH_LC_D
                             || c == nls_pkg::CH_UC_L);
   end

endmodule

[src/nls_queue.sv]
// Short queue of classified characters between front and back end.
// Depends on nls_pkg.
module nls_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  nls_pkg::class_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               not_empty,
   output nls_pkg::class_type head
);

   localparam int PW = (nls_pkg::QUEUE_DEPTH > 1) ? $clog2(nls_pkg::QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(nls_pkg::QUEUE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(nls_pkg::QUEUE_DEPTH);
   localparam logic [PW-1:0] LAST_C  = PW'(nls_pkg::QUEUE_DEPTH - 1);

   nls_pkg::class_type slot_ff [nls_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign full      = count_ff == DEPTH_C;
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_C) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_C) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/nls_back.sv]
// Back end of the numeric literal scanner: scan state machine and response register.
// Depends on nls_pkg.
module nls_back #(
   parameter int MAX_LENGTH = 255
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_valid,
   input  nls_pkg::class_type       q_head,
   output logic                     q_pop,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output nls_pkg::rsp_payload_type rsp_data
);

   localparam int CW = $clog2(MAX_LENGTH + 2);
   localparam logic [CW-1:0] LIMIT_C = CW'(MAX_LENGTH + 1);
   localparam logic [CW-1:0] MAX_C   = CW'(MAX_LENGTH);

   typedef enum logic [3:0] {
      PH_IDLE, PH_ZERO, PH_INT, PH_DOT, PH_FRAC, PH_EXP_START,
      PH_EXP_SIGN, PH_EXP_DIGITS, PH_HEX, PH_BIN, PH_OCT
   } phase_type;

   phase_type       phase_ff, phase_in;
   logic            seen_ff, seen_in;
   logic [CW-1:0]   count_ff, count_in;
   logic            rsp_valid_ff, rsp_valid_in;
   nls_pkg::rsp_payload_type rsp_data_ff;

   nls_pkg::class_type k;
   logic [1:0]      inc;
   logic [CW:0]     count_sum;
   logic [CW-1:0]   count_sat;
   logic            emit;
   logic [1:0]      emit_status;
   logic            emit_took;
   logic            emit_dot;
   logic            do_int;
   logic            do_finish;
   logic            out_free;
   logic            fire;
   nls_pkg::rsp_payload_type rsp_next;

   assign k         = q_head;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fire      = q_valid && (!emit || out_free);
   assign q_pop     = fire;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Saturating character count after this step's take
   assign count_sum = {1'b0, count_ff} + (CW + 1)'(inc);
   assign count_sat = (count_sum > {1'b0, LIMIT_C}) ? LIMIT_C : count_sum[CW-1:0];

   // Scan transition for the head character
   always_comb begin
      phase_in    = phase_ff;
      seen_in     = seen_ff;
      inc         = 2'd0;
      emit        = 1'b0;
      emit_status = nls_pkg::STATUS_OK;
      emit_took   = 1'b0;
      emit_dot    = 1'b0;
      do_int      = 1'b0;
      do_finish   = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (k.zero) begin
               inc      = 2'd1;
               seen_in  = 1'b1;
               phase_in = PH_ZERO;
            end else begin
               do_int = 1'b1;
            end
         end
         PH_ZERO: begin
            if (k.pfx_hex || k.pfx_bin || k.pfx_oct) begin
               inc      = 2'd1;
               seen_in  = 1'b0;
               phase_in = k.pfx_hex ? PH_HEX : (k.pfx_bin ? PH_BIN : PH_OCT);
            end else begin
               do_int = 1'b1;
            end
         end
         PH_INT: do_int = 1'b1;
         PH_DOT: begin
            if (k.dec) begin
               inc      = 2'd2;
               seen_in  = 1'b1;
               phase_in = PH_FRAC;
            end else begin
               // dot not followed by a digit is handed back
               emit        = 1'b1;
               emit_status = seen_ff ? nls_pkg::STATUS_OK : nls_pkg::STATUS_INVALID;
               emit_dot    = 1'b1;
            end
         end
         PH_FRAC: begin
            if (k.dec) begin
               inc = 2'd1;
            end else if (k.expo) begin
               inc      = 2'd1;
               phase_in = PH_EXP_START;
            end else begin
               do_finish = 1'b1;
            end
         end
         PH_EXP_START: begin
            if (k.sign) begin
               inc      = 2'd1;
               phase_in = PH_EXP_SIGN;
            end else if (k.dec) begin
               inc      = 2'd1;
               phase_in = PH_EXP_DIGITS;
            end else begin
               emit        = 1'b1;
               emit_status = nls_pkg::STATUS_INVALID;
            end
         end
         PH_EXP_SIGN: begin
            if (k.dec) begin
               inc      = 2'd1;
               phase_in = PH_EXP_DIGITS;
            end else begin
               emit        = 1'b1;
               emit_status = nls_pkg::STATUS_INVALID;
            end
         end
         PH_EXP_DIGITS: begin
            if (k.dec) begin
               inc = 2'd1;
            end else begin
               do_finish = 1'b1;
            end
         end
         PH_HEX: begin
            if (k.hex) begin
               inc     = 2'd1;
               seen_in = 1'b1;
            end else begin
               do_finish = 1'b1;
            end
         end
         PH_BIN: begin
            if (k.bin) begin
               inc     = 2'd1;
               seen_in = 1'b1;
            end else if (k.dec) begin
               emit        = 1'b1;
               emit_status = nls_pkg::STATUS_INVALID;
            end else begin
               do_finish = 1'b1;
            end
         end
         PH_OCT: begin
            if (k.oct) begin
               inc     = 2'd1;
               seen_in = 1'b1;
            end else if (k.dec) begin
               emit        = 1'b1;
               emit_status = nls_pkg::STATUS_INVALID;
            end else begin
               do_finish = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            seen_in  = 1'b0;
         end
      endcase

      // Integer digits, dot or exponent start; anything else ends the body
      if (do_int) begin
         if (k.dec) begin
            inc      = 2'd1;
            seen_in  = 1'b1;
            phase_in = PH_INT;
         end else if (k.dot) begin
            phase_in = PH_DOT;
         end else if (k.expo && seen_ff) begin
            inc      = 2'd1;
            phase_in = PH_EXP_START;
         end else begin
            do_finish = 1'b1;
         end
      end

      // Body ended: check digits and an optional suffix
      if (do_finish) begin
         emit = 1'b1;
         if (!seen_ff) begin
            emit_status = nls_pkg::STATUS_INVALID;
         end else if (k.alpha) begin
            if (k.suffix) begin
               inc       = 2'd1;
               emit_took = 1'b1;
            end else begin
               emit_status = nls_pkg::STATUS_INVALID;
            end
         end
      end
   end

   // Response fields; overlong valid literal turns into too long
   always_comb begin
      rsp_next.status         = emit_status;
      rsp_next.literal_length = 8'd0;
      rsp_next.took_current   = emit_took;
      rsp_next.dot_returned   = emit_dot;
      if (emit_status == nls_pkg::STATUS_OK) begin
         if (count_sat > MAX_C) begin
            rsp_next.status = nls_pkg::STATUS_TOO_LONG;
         end else begin
            rsp_next.literal_length = 8'(count_sat);
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (fire) begin
         count_in = emit ? '0 : count_sat;
      end
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // State and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         seen_ff      <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            phase_ff <= emit ? PH_IDLE : phase_in;
            seen_ff  <= emit ? 1'b0 : seen_in;
         end
         if (fire && emit) begin
            rsp_data_ff <= rsp_next;
         end
      end
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= LIMIT_C)
      else $error("character count above limit");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> (count_ff == '0 && !seen_ff))
      else $error("idle phase with leftover count or digit flag");

   // An overlong literal may still have taken its suffix
   a_took_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != nls_pkg::STATUS_OK |->
         (rsp_data_ff.literal_length == 8'd0 &&
          (rsp_data_ff.status == nls_pkg::STATUS_TOO_LONG || !rsp_data_ff.took_current)))
      else $error("failed literal reports length, or invalid one a taken suffix");

   a_took_dot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_data_ff.took_current && rsp_data_ff.dot_returned))
      else $error("suffix taken while dot returned");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall && q_valid && emit |=> !$past(fire))
      else $error("response overwritten while stalled");

endmodule

[bench/numeric_literal_scanner_checker.sv]
// Checker for the numeric literal scanner: tracks accepted characters, predicts each
// literal result and compares it with what the block returns.
// Depends on nls_pkg for payload types, status codes and character codes.
`timescale 1ns / 100ps
module numeric_literal_scanner_checker #(
   parameter int MAX_LENGTH = 255
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  nls_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  nls_pkg::rsp_payload_type rsp_data,
   output int                       error_count,
   output int                       pending_count,
   output int                       checked_count
);

   localparam int MAX_REPORTS = 10;

   typedef enum logic [3:0] {
      SCAN_IDLE,
      SCAN_ZERO,
      SCAN_INT,
      SCAN_DOT,
      SCAN_FRAC,
      SCAN_EXP_START,
      SCAN_EXP_SIGN,
      SCAN_EXP_DIGITS,
      SCAN_HEX,
      SCAN_BIN,
      SCAN_OCT
   } scan_phase_type;

   scan_phase_type           phase;
   bit                       digits_taken;
   int unsigned              char_count;
   nls_pkg::rsp_payload_type expected_literals[$];

   // Character classes
   function automatic bit is_decimal(logic [20:0] c);
      return c >= nls_pkg::CH_0 && c <= nls_pkg::CH_9;
   endfunction

   function automatic bit is_hex(logic [20:0] c);
      return is_decimal(c) || (c >= nls_pkg::CH_LC_A && c <= nls_pkg::CH_LC_F)
             || (c >= nls_pkg::CH_UC_A && c <= nls_pkg::CH_UC_F);
   endfunction

   function automatic bit is_letter(logic [20:0] c);
      return (c >= nls_pkg::CH_LC_A && c <= nls_pkg::CH_LC_Z)
             || (c >= nls_pkg::CH_UC_A && c <= nls_pkg::CH_UC_Z);
   endfunction

   function void restart_scan();
      phase        = SCAN_IDLE;
      digits_taken = 1'b0;
      char_count   = 0;
   endfunction

   // Count saturates one past the limit so that too-long stays visible
   function void take(int unsigned n);
      char_count += n;
      if (char_count > MAX_LENGTH + 1)
         char_count = MAX_LENGTH + 1;
   endfunction

   // Literal is over: queue the expected response and go back to idle
   function void close_literal(logic [1:0] status, bit took, bit dot);
      nls_pkg::rsp_payload_type lit;
      lit.status         = status;
      lit.literal_length = '0;
      lit.took_current   = took;
      lit.dot_returned   = dot;
      if (status == nls_pkg::STATUS_OK) begin
         if (char_count > MAX_LENGTH)
            lit.status = nls_pkg::STATUS_TOO_LONG;
         else
            lit.literal_length = char_count[7:0];
      end
      expected_literals.push_back(lit);
      restart_scan();
   endfunction

   // Number body ended on c: needs digits, and a letter must be a suffix
   function void end_body(logic [20:0] c);
      if (!digits_taken)
         close_literal(nls_pkg::STATUS_INVALID, 1'b0, 1'b0);
      else if (is_letter(c)) begin
         if (c == nls_pkg::CH_LC_F || c == nls_pkg::CH_LC_D || c == nls_pkg::CH_UC_L) begin
            take(1);
            close_literal(nls_pkg::STATUS_OK, 1'b1, 1'b0);
         end else
            close_literal(nls_pkg::STATUS_INVALID, 1'b0, 1'b0);
      end else
         close_literal(nls_pkg::STATUS_OK, 1'b0, 1'b0);
   endfunction

   function void integer_part(logic [20:0] c);
      if (is_decimal(c)) begin
         take(1);
         digits_taken = 1'b1;
         phase = SCAN_INT;
      end else if (c == nls_pkg::CH_DOT)
         phase = SCAN_DOT;
      else if ((c == nls_pkg::CH_LC_E || c == nls_pkg::CH_UC_E) && digits_taken) begin
         take(1);
         phase = SCAN_EXP_START;
      end else
         end_body(c);
   endfunction

   // One accepted request; end of text reads as a character matching nothing
   function void scan_char(nls_pkg::req_payload_type r);
      logic [20:0] c;
      c = r.end_of_text ? '0 : r.character;
      case (phase)
         SCAN_IDLE: begin
            if (c == nls_pkg::CH_0) begin
               take(1);
               digits_taken = 1'b1;
               phase = SCAN_ZERO;
            end else
               integer_part(c);
         end
         SCAN_ZERO: begin
            if (c == nls_pkg::CH_LC_X || c == nls_pkg::CH_UC_X) begin
               take(1);
               digits_taken = 1'b0;
               phase = SCAN_HEX;
            end else if (c == nls_pkg::CH_LC_B || c == nls_pkg::CH_UC_B) begin
               take(1);
               digits_taken = 1'b0;
               phase = SCAN_BIN;
            end else if (c == nls_pkg::CH_LC_O || c == nls_pkg::CH_UC_O) begin
               take(1);
               digits_taken = 1'b0;
               phase = SCAN_OCT;
            end else
               integer_part(c);
         end
         SCAN_INT: integer_part(c);
         SCAN_DOT: begin
            if (is_decimal(c)) begin
               take(2);
               digits_taken = 1'b1;
               phase = SCAN_FRAC;
            end else
               close_literal(digits_taken ? nls_pkg::STATUS_OK : nls_pkg::STATUS_INVALID,
                             1'b0, 1'b1);
         end
         SCAN_FRAC: begin
            if (is_decimal(c))
               take(1);
            else if (c == nls_pkg::CH_LC_E || c == nls_pkg::CH_UC_E) begin
               take(1);
               phase = SCAN_EXP_START;
            end else
               end_body(c);
         end
         SCAN_EXP_START: begin
            if (c == nls_pkg::CH_PLUS || c == nls_pkg::CH_MINUS) begin
               take(1);
               phase = SCAN_EXP_SIGN;
            end else if (is_decimal(c)) begin
               take(1);
               phase = SCAN_EXP_DIGITS;
            end else
               close_literal(nls_pkg::STATUS_INVALID, 1'b0, 1'b0);
         end
         SCAN_EXP_SIGN: begin
            if (is_decimal(c)) begin
               take(1);
               phase = SCAN_EXP_DIGITS;
            end else
               close_literal(nls_pkg::STATUS_INVALID, 1'b0, 1'b0);
         end
         SCAN_EXP_DIGITS: begin
            if (is_decimal(c))
               take(1);
            else
               end_body(c);
         end
         SCAN_HEX: begin
            if (is_hex(c)) begin
               take(1);
               digits_taken = 1'b1;
            end else
               end_body(c);
         end
         SCAN_BIN: begin
            if (c == nls_pkg::CH_0 || c == nls_pkg::CH_1) begin
               take(1);
               digits_taken = 1'b1;
            end else if (is_decimal(c))
               close_literal(nls_pkg::STATUS_INVALID, 1'b0, 1'b0);
            else
               end_body(c);
         end
         SCAN_OCT: begin
            if (c >= nls_pkg::CH_0 && c <= nls_pkg::CH_7) begin
               take(1);
               digits_taken = 1'b1;
            end else if (is_decimal(c))
               close_literal(nls_pkg::STATUS_INVALID, 1'b0, 1'b0);
            else
               end_body(c);
         end
         default: restart_scan();
      endcase
   endfunction

   function void flag_error(string what);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("%0t: %s", $time, what);
   endfunction

   // Compare a returned literal against the oldest prediction
   function void check_literal(nls_pkg::rsp_payload_type got);
      nls_pkg::rsp_payload_type want;
      if (expected_literals.size() == 0) begin
         flag_error($sformatf("unexpected response: status %0d length %0d took %0b dot %0b",
                              got.status, got.literal_length, got.took_current,
                              got.dot_returned));
         return;
      end
      want = expected_literals.pop_front();
      checked_count++;
      if (got.status !== want.status || got.literal_length !== want.literal_length ||
          got.took_current !== want.took_current || got.dot_returned !== want.dot_returned)
         flag_error($sformatf({"mismatch: expected status %0d length %0d took %0b dot %0b,",
                               " got status %0d length %0d took %0b dot %0b"},
                              want.status, want.literal_length, want.took_current,
                              want.dot_returned, got.status, got.literal_length,
                              got.took_current, got.dot_returned));
   endfunction

   // Requests are predicted before responses are checked at the same edge
   always @(posedge clock) begin
      if (reset) begin
         restart_scan();
         expected_literals.delete();
      end else begin
         if (req_valid && !req_stall)
            scan_char(req_data);
         if (rsp_valid && !rsp_stall)
            check_literal(rsp_data);
      end
      pending_count = expected_literals.size();
   end

endmodule

[bench/numeric_literal_scanner_tb.sv]
// Top of the numeric literal scanner bench: clock, reset, character stimulus,
// receiver stalls, watchdog and verdict.
// Depends on nls_pkg, numeric_literal_scanner and numeric_literal_scanner_checker.
`timescale 1ns / 100ps
module numeric_literal_scanner_tb;

   localparam int MAX_LENGTH     = 255;
   localparam int RANDOM_ITEMS   = 1900;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 48;
   localparam int SETTLE_CYCLES  = 20;

   localparam logic [20:0] CH_NUL         = 21'h00;
   localparam logic [20:0] CH_NEWLINE     = 21'h0A;
   localparam logic [20:0] CH_SPACE       = 21'h20;
   localparam logic [20:0] CH_RPAREN      = 21'h29;
   localparam logic [20:0] CH_COMMA       = 21'h2C;
   localparam logic [20:0] CH_SEMI        = 21'h3B;
   localparam logic [20:0] CH_ASCII_LAST  = 21'h7F;
   localparam logic [20:0] CODE_POINT_MID = 21'h0FFFFF;
   localparam logic [20:0] CODE_POINT_MAX = 21'h10FFFF;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   nls_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_stall;
   nls_pkg::rsp_payload_type rsp_data;

   int              error_count;
   int              pending_count;
   int              checked_count;

   nls_pkg::req_payload_type literal_text[$];
   int              items_sent;
   int              literal_count;
   int              held_off_cycles;
   int              stall_left;
   bit              send_pacing;
   bit              rsp_pacing;
   bit              hold_active;
   bit              rsp_taken;
   event            start_hold;

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   numeric_literal_scanner #(.MAX_LENGTH(MAX_LENGTH)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   numeric_literal_scanner_checker #(.MAX_LENGTH(MAX_LENGTH)) checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .error_count   (error_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   // Handshake sampling for the receiver and the summary
   always @(posedge clock) begin
      rsp_taken = rsp_valid && !rsp_stall;
      if (req_valid && req_stall)
         held_off_cycles++;
   end

   // Receiver: a random pause after each response, or a long hold-off
   always @(negedge clock) begin
      if (rsp_taken)
         stall_left = rsp_pacing ? $urandom_range(0, 3) : 0;
      if (hold_active)
         rsp_stall <= 1'b1;
      else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else
         rsp_stall <= 1'b0;
   end

   // Long hold-off, counted here while the sender keeps going
   always begin
      @(start_hold);
      hold_active = 1'b1;
      repeat (HOLD_CYCLES) @(negedge clock);
      hold_active = 1'b0;
   end

   // Watchdog on cycles with no handshake on either channel
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   function automatic nls_pkg::req_payload_type text_char(logic [20:0] c);
      nls_pkg::req_payload_type p;
      p.character   = c;
      p.end_of_text = 1'b0;
      return p;
   endfunction

   // End of text carries a random character that must be ignored
   function automatic nls_pkg::req_payload_type end_marker();
      nls_pkg::req_payload_type p;
      p.character   = 21'($urandom_range(0, CODE_POINT_MAX));
      p.end_of_text = 1'b1;
      return p;
   endfunction

   function void add(logic [20:0] c);
      literal_text.push_back(text_char(c));
   endfunction

   function automatic logic [20:0] dec_digit();
      return nls_pkg::CH_0 + 21'($urandom_range(0, 9));
   endfunction

   function automatic logic [20:0] hex_digit();
      case ($urandom_range(0, 2))
         0:       return dec_digit();
         1:       return nls_pkg::CH_LC_A + 21'($urandom_range(0, 5));
         default: return nls_pkg::CH_UC_A + 21'($urandom_range(0, 5));
      endcase
   endfunction

   // Characters that break or end a literal
   function automatic nls_pkg::req_payload_type stray_char();
      case ($urandom_range(0, 9))
         0:       return text_char(dec_digit());
         1:       return text_char(nls_pkg::CH_DOT);
         2:       return text_char($urandom_range(0, 1) ? nls_pkg::CH_PLUS : nls_pkg::CH_MINUS);
         3:       return text_char(nls_pkg::CH_LC_A + 21'($urandom_range(0, 25)));
         4:       return text_char(nls_pkg::CH_UC_A + 21'($urandom_range(0, 25)));
         5:       return text_char(nls_pkg::CH_LC_E);
         6:       return end_marker();
         7:       return text_char(21'($urandom_range(0, CODE_POINT_MAX)));
         8:       return text_char(CH_SPACE);
         default: return text_char(21'($urandom_range(0, CH_ASCII_LAST)));
      endcase
   endfunction

   function void add_terminator();
      case ($urandom_range(0, 5))
         0:       add(CH_SPACE);
         1:       add(CH_SEMI);
         2:       add(CH_COMMA);
         3:       add(CH_RPAREN);
         4:       add(CH_NEWLINE);
         default: literal_text.push_back(end_marker());
      endcase
   endfunction

   function void add_ending();
      if ($urandom_range(0, 2) == 0) begin
         case ($urandom_range(0, 2))
            0:       add(nls_pkg::CH_LC_F);
            1:       add(nls_pkg::CH_LC_D);
            default: add(nls_pkg::CH_UC_L);
         endcase
      end else
         add_terminator();
   endfunction

   // Decimal number: integer or leading dot, fraction, exponent, ending
   function void build_decimal();
      bit leading_dot;
      leading_dot = $urandom_range(0, 9) == 0;
      if (leading_dot) begin
         add(nls_pkg::CH_DOT);
         add(dec_digit());
      end else begin
         add($urandom_range(0, 3) == 0 ? nls_pkg::CH_0 : dec_digit());
         repeat ($urandom_range(0, 4)) add(dec_digit());
         if ($urandom_range(0, 1)) begin
            add(nls_pkg::CH_DOT);
            repeat ($urandom_range(1, 3)) add(dec_digit());
         end
      end
      if ($urandom_range(0, 2) == 0) begin
         add($urandom_range(0, 1) ? nls_pkg::CH_LC_E : nls_pkg::CH_UC_E);
         case ($urandom_range(0, 2))
            0: add(nls_pkg::CH_PLUS);
            1: add(nls_pkg::CH_MINUS);
            default: ;
         endcase
         repeat ($urandom_range(1, 3)) add(dec_digit());
      end
      add_ending();
   endfunction

   // Prefixed number; zero digits gives a bare prefix
   function void build_prefixed();
      int base;
      base = $urandom_range(0, 2);
      add(nls_pkg::CH_0);
      case (base)
         0:       add($urandom_range(0, 1) ? nls_pkg::CH_LC_X : nls_pkg::CH_UC_X);
         1:       add($urandom_range(0, 1) ? nls_pkg::CH_LC_B : nls_pkg::CH_UC_B);
         default: add($urandom_range(0, 1) ? nls_pkg::CH_LC_O : nls_pkg::CH_UC_O);
      endcase
      repeat ($urandom_range(0, 6)) begin
         case (base)
            0:       add(hex_digit());
            1:       add(nls_pkg::CH_0 + 21'($urandom_range(0, 1)));
            default: add(nls_pkg::CH_0 + 21'($urandom_range(0, 7)));
         endcase
      end
      add_ending();
   endfunction

   function void build_long(int digit_count, bit with_suffix);
      repeat (digit_count) add(dec_digit());
      if (with_suffix)
         add(nls_pkg::CH_UC_L);
      else
         add_terminator();
   endfunction

   // Present one request after a random gap and wait for it to be taken
   task automatic send_char(nls_pkg::req_payload_type p);
      int gap;
      gap = send_pacing ? $urandom_range(0, 3) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_text();
      while (literal_text.size() > 0)
         send_char(literal_text.pop_front());
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      int random_start;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_stall   = 1'b0;
      send_pacing = 1'b1;
      rsp_pacing  = 1'b1;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: prefixes, bad digits, held dot, empty exponent, field extremes
      add(nls_pkg::CH_0); add(nls_pkg::CH_UC_X); add(nls_pkg::CH_1);
      add(nls_pkg::CH_LC_F); add(nls_pkg::CH_UC_L);
      add(nls_pkg::CH_0); add(nls_pkg::CH_LC_B); add(nls_pkg::CH_9);
      add(nls_pkg::CH_0); add(nls_pkg::CH_UC_O); add(nls_pkg::CH_9);
      add(nls_pkg::CH_1); add(nls_pkg::CH_DOT); literal_text.push_back(end_marker());
      add(nls_pkg::CH_DOT); add(CODE_POINT_MAX);
      add(nls_pkg::CH_9); add(nls_pkg::CH_LC_E); add(nls_pkg::CH_PLUS); add(CH_SEMI);
      add(nls_pkg::CH_0); add(nls_pkg::CH_LC_X); add(CODE_POINT_MID);
      add(nls_pkg::CH_7); add(nls_pkg::CH_LC_Z);
      add(CH_NUL);
      send_text();

      // Random literals, mostly well formed, some broken or pure noise
      random_start = items_sent;
      while (items_sent - random_start < RANDOM_ITEMS) begin
         if (literal_count % 40 == 0) begin
            send_pacing = $urandom_range(0, 3) != 0;
            rsp_pacing  = $urandom_range(0, 3) != 0;
         end
         if (literal_count == 25 || literal_count == 140)
            -> start_hold;
         if (literal_count == 60 || literal_count == 200)
            wait_for_drain();
         if (literal_count == 45)
            build_long(MAX_LENGTH, 1'b0);
         else if (literal_count == 95)
            build_long(MAX_LENGTH + 1, 1'b0);
         else if (literal_count == 120)
            build_long(MAX_LENGTH - 1, 1'b1);
         else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4: build_decimal();
               5, 6, 7:       build_prefixed();
               8:             repeat ($urandom_range(1, 3)) literal_text.push_back(stray_char());
               default: begin
                  if ($urandom_range(0, 99) == 0)
                     build_long($urandom_range(MAX_LENGTH - 4, MAX_LENGTH + 4),
                                $urandom_range(0, 1) != 0);
                  else
                     build_decimal();
               end
            endcase
            // Corrupt one character now and then
            if ($urandom_range(0, 6) == 0)
               literal_text[$urandom_range(0, literal_text.size() - 1)] = stray_char();
         end
         send_text();
         literal_count++;
      end

      // Close whatever literal is still open
      literal_text.push_back(end_marker());
      send_text();
      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("run: %0d characters in %0d literal sequences, %0d results checked",
               items_sent, literal_count, checked_count);
      $display("run: %0d cycles with the request side held off, lengths up to %0d",
               held_off_cycles, MAX_LENGTH + 1);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
src/nls_pkg.sv
src/nls_front.sv
src/nls_queue.sv
src/nls_back.sv
src/numeric_literal_scanner.sv
bench/numeric_literal_scanner_checker.sv
bench/numeric_literal_scanner_tb.sv
